@@ hdl/hntg_pkg.sv @@
// hntg_pkg: shared types, constants and helpers for the hash noise terrain grid
// holds the queue word layout, the result word layout and the back end state type
// no dependencies
package hntg_pkg;

    // grid limits
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;

    // field widths
    localparam int COL_W  = 8;
    localparam int ROW_W  = 8;
    localparam int SIZE_W = 9;
    localparam int ID_W   = 17;
    localparam int WORD_W = 64;

    localparam logic [SIZE_W-1:0] MAX_W_SZ = SIZE_W'(MAX_WIDTH);
    localparam logic [SIZE_W-1:0] MAX_H_SZ = SIZE_W'(MAX_HEIGHT);

    // mixer constants
    localparam logic [WORD_W-1:0] MIX_X      = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [WORD_W-1:0] MIX_A      = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [WORD_W-1:0] MIX_Y      = 64'h94D0_49BB_1331_11EB;
    localparam logic [WORD_W-1:0] SPAWN_SALT = 64'hA5B3_5705_893B_9ADF;
    localparam int                SHIFT_A    = 30;
    localparam int                SHIFT_B    = 31;

    // configuration register indexes
    typedef logic [2:0] t_cfg_idx;
    localparam t_cfg_idx CFG_SEED        = 3'd0;
    localparam t_cfg_idx CFG_SOIL_THR    = 3'd1;
    localparam t_cfg_idx CFG_SPAWN_DENS  = 3'd2;
    localparam t_cfg_idx CFG_GRID_WIDTH  = 3'd3;
    localparam t_cfg_idx CFG_GRID_HEIGHT = 3'd4;

    // result kinds
    localparam logic KIND_CELL     = 1'b0;
    localparam logic KIND_FALLBACK = 1'b1;

    // queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    typedef struct packed {
        logic [COL_W-1:0]  x;
        logic [ROW_W-1:0]  y;
        logic [SIZE_W-1:0] w;
        logic              fresh;
        logic              grid_end;
    } t_cell_req;

    typedef struct packed {
        logic             kind;
        logic [ID_W-1:0]  cell_id;
        logic [COL_W-1:0] cell_x;
        logic [ROW_W-1:0] cell_y;
        logic             soil;
        logic             spawn;
        logic             link_left;
        logic             link_up;
        logic             grid_end;
        logic             last;
    } t_cell_res;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MIX,
        B_MUL0,
        B_MUL1,
        B_MUL2,
        B_FIN,
        B_EVAL,
        B_FALLBACK
    } t_back_state;

    // zero reads as one, above the limit saturates
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] lim);
        logic [SIZE_W-1:0] r;
        if (v == '0) begin
            r = SIZE_W'(1);
        end else if (v > lim) begin
            r = lim;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

@@ hdl/hntg_front.sv @@
// hntg_front: raster position tracking for the terrain grid
// accepts input words and pushes one cell request per word into the queue
// depends on hntg_pkg
module hntg_front
    import hntg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_restart,
    input  logic [SIZE_W-1:0] i_grid_w,
    input  logic [SIZE_W-1:0] i_grid_h,
    input  logic              i_q_full,
    output logic              o_in_ready,
    output logic              o_push,
    output t_cell_req         o_req
);

    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic              r_fresh_next, n_fresh_next;

    logic [SIZE_W-1:0] w, h;
    logic [COL_W-1:0]  col0, col1, x;
    logic [ROW_W-1:0]  row0, y;
    logic [SIZE_W-1:0] row1;
    logic              wrap, ovf, grid_end;
    logic [SIZE_W-1:0] x_inc, y_inc;

    // nothing is taken while reset is held
    assign o_in_ready = i_rst_n && !i_q_full;
    assign o_push     = i_in_valid && o_in_ready;

    always_comb begin
        w    = clamp_size(i_grid_w, MAX_W_SZ);
        h    = clamp_size(i_grid_h, MAX_H_SZ);
        col0 = i_restart ? '0 : r_col;
        row0 = i_restart ? '0 : r_row;
        // width shrunk under the current column: go to the next row
        wrap = {1'b0, col0} >= w;
        col1 = wrap ? '0 : col0;
        row1 = {1'b0, row0} + SIZE_W'(wrap);
        // height shrunk under the current row: new grid
        ovf  = row1 >= h;
        x    = ovf ? '0 : col1;
        y    = ovf ? '0 : row1[ROW_W-1:0];

        x_inc    = {1'b0, x} + SIZE_W'(1);
        y_inc    = {1'b0, y} + SIZE_W'(1);
        grid_end = (x_inc >= w) && (y_inc >= h);

        o_req.x        = x;
        o_req.y        = y;
        o_req.w        = w;
        o_req.fresh    = i_restart || ovf || r_fresh_next;
        o_req.grid_end = grid_end;

        n_col        = r_col;
        n_row        = r_row;
        n_fresh_next = r_fresh_next;
        if (o_push) begin
            n_fresh_next = grid_end;
            if (grid_end) begin
                n_col = '0;
                n_row = '0;
            end else if (x_inc >= w) begin
                n_col = '0;
                n_row = y_inc[ROW_W-1:0];
            end else begin
                n_col = x_inc[COL_W-1:0];
                n_row = y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col        <= '0;
            r_row        <= '0;
            r_fresh_next <= 1'b1;
        end else begin
            r_col        <= n_col;
            r_row        <= n_row;
            r_fresh_next <= n_fresh_next;
        end
    end

endmodule

@@ hdl/hntg_queue.sv @@
// hntg_queue: short fifo of cell requests between front and back
// lets the front keep accepting while the back works or stalls
// depends on hntg_pkg
module hntg_queue
    import hntg_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cell_req i_req,
    input  logic      i_pop,
    output t_cell_req o_head,
    output logic      o_full,
    output logic      o_empty
);

    t_cell_req       r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp, r_rp;
    logic [Q_AW:0]   r_count;

    assign o_head  = r_mem[r_rp];
    assign o_full  = r_count == (Q_AW+1)'(Q_DEPTH);
    assign o_empty = r_count == '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wp + Q_AW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rp + Q_AW'(1);
            end
            r_count <= r_count + (Q_AW+1)'(i_push) - (Q_AW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_req;
        end
    end

    pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");

endmodule

@@ hdl/hntg_back.sv @@
// hntg_back: hashes each cell, tracks soil neighbours, best score and spawns
// uses one shared 32x32 multiplier and a 1-bit row memory; owns the output register
// depends on hntg_pkg
module hntg_back
    import hntg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [WORD_W-1:0] i_seed,
    input  logic [WORD_W-1:0] i_soil_thr,
    input  logic [WORD_W-1:0] i_spawn_dens,
    input  t_cell_req         i_head,
    input  logic              i_empty,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_cell_res         o_out
);

    t_back_state r_state, n_state;

    // cell under work
    logic [COL_W-1:0]  r_x;
    logic [ROW_W-1:0]  r_y;
    logic [SIZE_W-1:0] r_w;
    logic [ID_W-1:0]   r_id;
    logic              r_end;
    logic [WORD_W-1:0] r_xm, r_ym;
    logic              r_pass;

    // hash datapath
    logic [WORD_W-1:0] r_m, r_p, r_raw, r_score;
    logic [31:0]       r_hi;

    // neighbour and tracking state
    logic              r_above_mem [MAX_WIDTH];
    logic              r_above_q;
    logic              r_left;
    logic [WORD_W-1:0] r_best_score;
    logic [COL_W-1:0]  r_best_x;
    logic [ROW_W-1:0]  r_best_y;
    logic              r_best_valid;
    logic              r_spawn_seen;

    logic              r_out_valid;
    t_cell_res         r_out;

    logic              out_free, load_fire, eval_fire, fb_fire;
    logic [WORD_W-1:0] salt_seed, v0, mixed, fin_sum, fin_hash;
    logic [31:0]       mul_a, mul_b;
    logic [WORD_W-1:0] mul_p;
    logic [ID_W-1:0]   fb_id;
    logic              soil, spawn, take_best, ss_n, bv_n, fallback, ll, lu;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_pop       = load_fire;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE:     if (!i_empty) n_state = B_MIX;
            B_MIX:      n_state = B_MUL0;
            B_MUL0:     n_state = B_MUL1;
            B_MUL1:     n_state = B_MUL2;
            B_MUL2:     n_state = B_FIN;
            B_FIN:      n_state = r_pass ? B_EVAL : B_MIX;
            B_EVAL:     if (out_free) n_state = fallback ? B_FALLBACK : B_IDLE;
            B_FALLBACK: if (out_free) n_state = B_IDLE;
            default:    n_state = B_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        load_fire = 1'b0;
        eval_fire = 1'b0;
        fb_fire   = 1'b0;
        case (r_state)
            B_IDLE:     load_fire = !i_empty;
            B_EVAL:     eval_fire = out_free;
            B_FALLBACK: fb_fire   = out_free;
            default:    ;
        endcase
    end

    // datapath
    always_comb begin
        salt_seed = r_pass ? (i_seed ^ SPAWN_SALT) : i_seed;
        v0        = salt_seed + r_xm;
        mixed     = v0 ^ (v0 >> SHIFT_A);

        // low 64 bits of m * MIX_A over three partial products
        mul_a = (r_state == B_MUL1) ? r_m[63:32] : r_m[31:0];
        mul_b = (r_state == B_MUL2) ? MIX_A[63:32] : MIX_A[31:0];
        mul_p = 64'(mul_a) * 64'(mul_b);

        fin_sum  = r_p + {r_hi, 32'b0} + r_ym;
        fin_hash = fin_sum ^ (fin_sum >> SHIFT_B);

        soil      = r_raw >= i_soil_thr;
        spawn     = soil && (r_score <= i_spawn_dens);
        take_best = soil && (!r_best_valid || (r_score > r_best_score));
        ss_n      = r_spawn_seen || spawn;
        bv_n      = r_best_valid || soil;
        fallback  = r_end && !ss_n && bv_n;
        ll        = soil && (r_x != '0) && r_left;
        lu        = soil && (r_y != '0) && r_above_q;

        // fallback id uses the width of the final cell
        fb_id = ID_W'(r_best_y) * ID_W'(r_w) + ID_W'(r_best_x) + ID_W'(2);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= B_IDLE;
            r_out_valid  <= 1'b0;
            r_left       <= 1'b0;
            r_best_valid <= 1'b0;
            r_spawn_seen <= 1'b0;
            r_best_score <= '0;
            r_best_x     <= '0;
            r_best_y     <= '0;
        end else begin
            r_state <= n_state;
            if (eval_fire || fb_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (load_fire && i_head.fresh) begin
                // new grid clears tracking
                r_left       <= 1'b0;
                r_best_valid <= 1'b0;
                r_spawn_seen <= 1'b0;
                r_best_score <= '0;
                r_best_x     <= '0;
                r_best_y     <= '0;
            end else if (eval_fire) begin
                r_left       <= soil;
                r_best_valid <= bv_n;
                r_spawn_seen <= ss_n;
                if (take_best) begin
                    r_best_score <= r_score;
                    r_best_x     <= r_x;
                    r_best_y     <= r_y;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (load_fire) begin
            r_x    <= i_head.x;
            r_y    <= i_head.y;
            r_w    <= i_head.w;
            r_end  <= i_head.grid_end;
            r_id   <= ID_W'(i_head.y) * ID_W'(i_head.w) + ID_W'(i_head.x) + ID_W'(2);
            r_xm   <= MIX_X * WORD_W'(i_head.x);
            r_ym   <= MIX_Y * WORD_W'(i_head.y);
            r_pass <= 1'b0;
        end
        case (r_state)
            B_MIX:   r_m  <= mixed;
            B_MUL0:  r_p  <= mul_p;
            B_MUL1:  r_hi <= mul_p[31:0];
            B_MUL2:  r_hi <= r_hi + mul_p[31:0];
            B_FIN: begin
                if (r_pass) begin
                    r_score <= fin_hash;
                end else begin
                    r_raw  <= fin_hash;
                    r_pass <= 1'b1;
                end
            end
            default: ;
        endcase
        if (eval_fire) begin
            r_out.kind      <= KIND_CELL;
            r_out.cell_id   <= r_id;
            r_out.cell_x    <= r_x;
            r_out.cell_y    <= r_y;
            r_out.soil      <= soil;
            r_out.spawn     <= spawn;
            r_out.link_left <= ll;
            r_out.link_up   <= lu;
            r_out.grid_end  <= r_end;
            r_out.last      <= !fallback;
        end else if (fb_fire) begin
            r_out.kind      <= KIND_FALLBACK;
            r_out.cell_id   <= fb_id;
            r_out.cell_x    <= r_best_x;
            r_out.cell_y    <= r_best_y;
            r_out.soil      <= 1'b1;
            r_out.spawn     <= 1'b1;
            r_out.link_left <= 1'b0;
            r_out.link_up   <= 1'b0;
            r_out.grid_end  <= 1'b1;
            r_out.last      <= 1'b1;
        end
    end

    // soil flags of the previous row, one per column
    always_ff @(posedge i_clk) begin
        if (eval_fire) begin
            r_above_mem[r_x] <= soil;
        end
        if (load_fire) begin
            r_above_q <= r_above_mem[i_head.x];
        end
    end

    fallback_after_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == B_FALLBACK |-> $past(r_state) == B_EVAL || $past(r_state) == B_FALLBACK)
        else $error("fallback entered without a cell result");

    open_word_awaits_fallback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.last |-> r_state == B_FALLBACK)
        else $error("non-final word without pending fallback");

    eval_has_both_hashes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == B_EVAL |-> r_pass)
        else $error("evaluation before salted hash");

endmodule

@@ hdl/hash_noise_terrain_grid.sv @@
// hash_noise_terrain_grid: top level of the hash noise terrain generator
// holds the configuration registers and connects front, queue and back
// depends on hntg_pkg, hntg_front, hntg_queue, hntg_back
//
//   channel   direction   handshake                      payload
//   ------    ---------   ---------                      -------
//   in        input       i_in_valid / o_in_ready        i_restart
//   out       output      o_out_valid / i_out_ready      o_kind .. o_last
//   cfg       input       i_cfg_we (no wait)             i_cfg_idx, i_cfg_data
//
// back end per cell word: a load state, two hash passes (mix, three multiply steps,
// finish) on the shared 32x32 multiplier, then an evaluate state
// a grid's final word may be followed by a fallback spawn word
// the front accepts up to two words ahead while the back works or the output stalls
// reset is synchronous, active low; the row memory has no reset and is not cleared
module hash_noise_terrain_grid
    import hntg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_we,
    input  t_cfg_idx           i_cfg_idx,
    input  logic [WORD_W-1:0]  i_cfg_data,
    // input words
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_restart,
    // result words
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_kind,
    output logic [ID_W-1:0]    o_cell_id,
    output logic [COL_W-1:0]   o_cell_x,
    output logic [ROW_W-1:0]   o_cell_y,
    output logic               o_soil,
    output logic               o_spawn,
    output logic               o_link_left,
    output logic               o_link_up,
    output logic               o_grid_end,
    output logic               o_last
);

    // configuration registers
    logic [WORD_W-1:0] r_seed;
    logic [WORD_W-1:0] r_soil_thr;
    logic [WORD_W-1:0] r_spawn_dens;
    logic [SIZE_W-1:0] r_grid_w;
    logic [SIZE_W-1:0] r_grid_h;

    // front to queue to back
    logic      push, pop, q_full, q_empty;
    t_cell_req req, head;
    t_cell_res res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed       <= '0;
            r_soil_thr   <= 64'h8000_0000_0000_0000;
            r_spawn_dens <= '0;
            r_grid_w     <= MAX_W_SZ;
            r_grid_h     <= MAX_H_SZ;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SEED:        r_seed       <= i_cfg_data;
                CFG_SOIL_THR:    r_soil_thr   <= i_cfg_data;
                CFG_SPAWN_DENS:  r_spawn_dens <= i_cfg_data;
                CFG_GRID_WIDTH:  r_grid_w     <= i_cfg_data[SIZE_W-1:0];
                CFG_GRID_HEIGHT: r_grid_h     <= i_cfg_data[SIZE_W-1:0];
                default:         ; // unknown index is dropped
            endcase
        end
    end

    // raster position and grid boundaries
    hntg_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_restart  (i_restart),
        .i_grid_w   (r_grid_w),
        .i_grid_h   (r_grid_h),
        .i_q_full   (q_full),
        .o_in_ready (o_in_ready),
        .o_push     (push),
        .o_req      (req)
    );

    // decouples the front from the hash engine
    hntg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_req   (req),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // hashing, neighbour links, best score and fallback
    hntg_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_seed       (r_seed),
        .i_soil_thr   (r_soil_thr),
        .i_spawn_dens (r_spawn_dens),
        .i_head       (head),
        .i_empty      (q_empty),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out        (res)
    );

    // result word onto its ports
    assign o_kind      = res.kind;
    assign o_cell_id   = res.cell_id;
    assign o_cell_x    = res.cell_x;
    assign o_cell_y    = res.cell_y;
    assign o_soil      = res.soil;
    assign o_spawn     = res.spawn;
    assign o_link_left = res.link_left;
    assign o_link_up   = res.link_up;
    assign o_grid_end  = res.grid_end;
    assign o_last      = res.last;

endmodule
